/* hw/rtl/hmc32_pkg.sv */
`timescale 1ns / 1ps

package hmc32_pkg;

   // Code geometry
   localparam int unsigned CodeBits   = 32;
   localparam int unsigned DataBits   = 27;
   localparam int unsigned ParityBits = 5;

   typedef logic [CodeBits-1:0]   codeword_type;
   typedef logic [DataBits-1:0]   data_type;
   typedef logic [ParityBits-1:0] syndrome_type;
   typedef logic [4:0]            bit_idx_type;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   // Coverage of each parity bit over word bits 0..30; bit 31 is never covered
   localparam codeword_type CoverMask [ParityBits] = '{
      32'h5555_5555, 32'h6666_6666, 32'h7878_7878, 32'h7F80_7F80, 32'h7FFF_8000
   };

   // Word bit of each parity bit (positions 1, 2, 4, 8, 16)
   localparam bit_idx_type ParityPos [ParityBits] = '{
      5'd0, 5'd1, 5'd3, 5'd7, 5'd15
   };

   // Word bit of each data bit, in ascending order
   localparam bit_idx_type DataPos [DataBits] = '{
      5'd2,  5'd4,  5'd5,  5'd6,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
      5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
      5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
   };

   // Place data bits into the non-parity positions
   function automatic codeword_type scatter_data(data_type data);
      codeword_type word;
      word = '0;
      for (int k = 0; k < DataBits; k++) begin
         word[DataPos[k]] = data[k];
      end
      return word;
   endfunction

   // Pull data bits back out of the non-parity positions
   function automatic data_type gather_data(codeword_type word);
      data_type data;
      for (int k = 0; k < DataBits; k++) begin
         data[k] = word[DataPos[k]];
      end
      return data;
   endfunction

   // Even parity of each coverage group; the masks do not overlap other
   // parity positions, so the groups are independent
   function automatic syndrome_type syndrome(codeword_type word);
      syndrome_type syn;
      for (int i = 0; i < ParityBits; i++) begin
         syn[i] = ^(word & CoverMask[i]);
      end
      return syn;
   endfunction

endpackage

/* hw/rtl/hamming_32_encode_decode.sv */
`timescale 1ns / 1ps

// Hamming single-error-correcting coder for 32-bit words. Take one word per
// clock on start (busy stays low, so every start is taken); the result appears
// on rsp_result_word with rsp_strobe for one cycle, and words come out in the
// order they went in. The receiver cannot stall: it must take each result in
// the cycle that rsp_strobe marks. The latency is set by the input register and
// the result register; all coding logic sits between the two. In encode mode
// the low 27 bits are spread over the data positions and the five even-parity
// bits are filled in. In decode mode a nonzero syndrome flips the named bit and
// the 27 data bits come out zero-extended. Position 32 (bit 31) is covered by
// no parity bit, so an error there passes into data bit 26; a double error is
// miscorrected.
module hamming_32_encode_decode (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [31:0] req_data_word,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result_word
);

   logic                     req_vld_ff;
   logic                     mode_ff;
   hmc32_pkg::codeword_type  word_ff;
   logic                     rsp_strobe_ff;
   logic                     rsp_strobe_in;
   hmc32_pkg::codeword_type  rsp_word_ff;
   hmc32_pkg::codeword_type  rsp_word_in;

   hmc32_pkg::codeword_type  enc_scatter;
   hmc32_pkg::syndrome_type  enc_parity;
   hmc32_pkg::codeword_type  enc_word;
   hmc32_pkg::syndrome_type  dec_syn;
   hmc32_pkg::codeword_type  dec_fixed;
   hmc32_pkg::codeword_type  dec_word;

   // Never stall the requester
   assign busy = 1'b0;

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
      mode_ff <= req_mode;
      word_ff <= req_data_word;
   end

   // Encode: scatter data, then fill the parity positions
   always_comb begin
      enc_scatter = hmc32_pkg::scatter_data(word_ff[hmc32_pkg::DataBits-1:0]);
      enc_parity  = hmc32_pkg::syndrome(enc_scatter);
      enc_word    = enc_scatter;
      for (int i = 0; i < hmc32_pkg::ParityBits; i++) begin
         enc_word[hmc32_pkg::ParityPos[i]] = enc_parity[i];
      end
   end

   // Decode: flip the bit the syndrome names, then gather data
   always_comb begin
      dec_syn   = hmc32_pkg::syndrome(word_ff);
      dec_fixed = word_ff;
      if (dec_syn != '0) begin
         dec_fixed = word_ff ^ (hmc32_pkg::codeword_type'(1) << (dec_syn - 5'd1));
      end
      dec_word = {{(hmc32_pkg::CodeBits-hmc32_pkg::DataBits){1'b0}},
                  hmc32_pkg::gather_data(dec_fixed)};
   end

   // Select the result for the mode
   always_comb begin
      rsp_strobe_in = req_vld_ff;
      case (mode_ff)
         hmc32_pkg::MODE_ENCODE: rsp_word_in = enc_word;
         hmc32_pkg::MODE_DECODE: rsp_word_in = dec_word;
         default:                rsp_word_in = enc_word;
      endcase
   end

   // Hold the result for its one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_word = rsp_word_ff;

endmodule

/* hw/rtl/hmc32_checker.sv */
`timescale 1ns / 1ps

module hmc32_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_mode,
   input logic [31:0] req_data_word,
   input logic        rsp_strobe,
   input logic [31:0] rsp_result_word
);

   // Every taken word comes back as a result strobe, after the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("taken word produced no result");

   // No result without a taken word
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a taken word");

   // Decoded data is zero-extended
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_mode, 2) == hmc32_pkg::MODE_DECODE)
      |-> rsp_result_word[31:hmc32_pkg::DataBits] == '0)
      else $error("decoded word has high bits set");

   // An encoded word has a zero syndrome and carries the input data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_mode, 2) == hmc32_pkg::MODE_ENCODE)
      |-> (hmc32_pkg::syndrome(rsp_result_word) == '0) &&
          (hmc32_pkg::gather_data(rsp_result_word) ==
           $past(req_data_word[hmc32_pkg::DataBits-1:0], 2)))
      else $error("encoded word is not a clean codeword of the input");

endmodule

bind hamming_32_encode_decode hmc32_checker u_hmc32_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = 1'b0;
   logic [31:0] req_data_word = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_result_word;

   logic [31:0] pending_results [$];
   int unsigned fail_count = 0;

   hamming_32_encode_decode dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_data_word   (req_data_word),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_word (rsp_result_word)
   );

   // Free-running clock, 20 ns period
   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the pipeline hangs
   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Positions 1, 2, 4, 8 and 16 hold the check bits
   function automatic bit is_check_position(int unsigned pos);
      return (pos == 1) || (pos == 2) || (pos == 4) || (pos == 8) || (pos == 16);
   endfunction

   // Check bit p covers every position 1..31 whose bit p is set; position 32 is bare
   function automatic logic [4:0] syndrome_of(logic [31:0] word);
      logic [4:0] syn;
      syn = '0;
      for (int p = 0; p < 5; p++) begin
         for (int unsigned pos = 1; pos <= 31; pos++) begin
            if (((pos >> p) & 1) != 0) begin
               syn[p] = syn[p] ^ word[pos-1];
            end
         end
      end
      return syn;
   endfunction

   // Expected result word for one accepted word
   function automatic logic [31:0] code_word_result(hmc32_pkg::mode_type mode,
                                                    logic [31:0] word);
      logic [31:0] cw;
      logic [31:0] data;
      logic [4:0]  syn;
      int unsigned k;
      cw   = '0;
      data = '0;
      k    = 0;
      if (mode == hmc32_pkg::MODE_ENCODE) begin
         // spread the low 27 bits over the data positions, then fill the check bits
         for (int unsigned pos = 1; pos <= 32; pos++) begin
            if (!is_check_position(pos)) begin
               cw[pos-1] = word[k];
               k++;
            end
         end
         syn = syndrome_of(cw);
         for (int p = 0; p < 5; p++) begin
            cw[(1 << p) - 1] = syn[p];
         end
         return cw;
      end
      // flip the named bit, then pull the data bits back out
      syn = syndrome_of(word);
      if (syn != '0) begin
         word[syn - 1] = ~word[syn - 1];
      end
      for (int unsigned pos = 1; pos <= 32; pos++) begin
         if (!is_check_position(pos)) begin
            data[k] = word[pos-1];
            k++;
         end
      end
      return data;
   endfunction

   // Record each accepted word, then check each strobed result against the oldest one
   always @(posedge clock) begin
      logic [31:0] expected_word;
      if (!reset) begin
         if (start && !busy) begin
            pending_results.push_back(
               code_word_result(hmc32_pkg::mode_type'(req_mode), req_data_word));
         end
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("rsp_result_word: unexpected result %h", rsp_result_word);
               fail_count++;
            end else begin
               expected_word = pending_results.pop_front();
               if (rsp_result_word !== expected_word) begin
                  $error("rsp_result_word mismatch: expected %h, actual %h",
                         expected_word, rsp_result_word);
                  fail_count++;
               end
            end
         end
      end
   end

   // Present one word and hold it until taken; start stays high for the next word
   task automatic send_word(hmc32_pkg::mode_type mode, logic [31:0] word);
      req_mode      <= mode;
      req_data_word <= word;
      start         <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // Drop start for a number of cycles
   task automatic idle_cycles(int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic test_encode_extremes();
      send_word(hmc32_pkg::MODE_ENCODE, 32'h0000_0000);
      send_word(hmc32_pkg::MODE_ENCODE, 32'h07FF_FFFF);
      send_word(hmc32_pkg::MODE_ENCODE, 32'hFFFF_FFFF);
      send_word(hmc32_pkg::MODE_ENCODE, 32'hF800_0000);
      send_word(hmc32_pkg::MODE_ENCODE, 32'h0555_5555);
      send_word(hmc32_pkg::MODE_ENCODE, 32'h02AA_AAAA);
      idle_cycles(3);
   endtask

   task automatic test_decode_clean();
      send_word(hmc32_pkg::MODE_DECODE,
                code_word_result(hmc32_pkg::MODE_ENCODE, 32'h07FF_FFFF));
      send_word(hmc32_pkg::MODE_DECODE,
                code_word_result(hmc32_pkg::MODE_ENCODE, 32'h02AA_AAAA));
      send_word(hmc32_pkg::MODE_DECODE, 32'h0000_0000);
      idle_cycles(2);
   endtask

   task automatic test_decode_single_error();
      logic [31:0] cw;
      cw = code_word_result(hmc32_pkg::MODE_ENCODE, 32'h0123_4567);
      send_word(hmc32_pkg::MODE_DECODE, cw ^ 32'h0000_0001);
      send_word(hmc32_pkg::MODE_DECODE, cw ^ 32'h0000_0002);
      send_word(hmc32_pkg::MODE_DECODE, cw ^ 32'h0000_0004);
      send_word(hmc32_pkg::MODE_DECODE, cw ^ 32'h0000_8000);
      send_word(hmc32_pkg::MODE_DECODE, cw ^ 32'h4000_0000);
      idle_cycles(1);
   endtask

   // Uncovered top bit, double error, and raw words with no valid structure
   task automatic test_decode_corner_cases();
      logic [31:0] cw;
      cw = code_word_result(hmc32_pkg::MODE_ENCODE, 32'h0765_4321);
      send_word(hmc32_pkg::MODE_DECODE, cw ^ 32'h8000_0000);
      send_word(hmc32_pkg::MODE_DECODE, cw ^ 32'h0000_0208);
      send_word(hmc32_pkg::MODE_DECODE, 32'hFFFF_FFFF);
      send_word(hmc32_pkg::MODE_DECODE, 32'h8000_0000);
      idle_cycles(4);
   endtask

   // Random encode requests, coded words with zero, one or two flipped bits, and raw noise
   task automatic test_random_traffic(int unsigned n_words);
      int unsigned sent;
      int unsigned burst_len;
      int unsigned kind;
      int unsigned bit_a;
      int unsigned bit_b;
      logic [31:0] cw;
      sent = 0;
      while (sent < n_words) begin
         burst_len = $urandom_range(1, 20);
         for (int unsigned i = 0; i < burst_len && sent < n_words; i++) begin
            kind = $urandom_range(0, 9);
            cw   = code_word_result(hmc32_pkg::MODE_ENCODE, $urandom());
            if (kind <= 3) begin
               send_word(hmc32_pkg::MODE_ENCODE, $urandom());
            end else if (kind == 4) begin
               send_word(hmc32_pkg::MODE_DECODE, $urandom());
            end else if (kind <= 6) begin
               send_word(hmc32_pkg::MODE_DECODE, cw);
            end else if (kind <= 8) begin
               bit_a = $urandom_range(0, 31);
               send_word(hmc32_pkg::MODE_DECODE, cw ^ (32'h1 << bit_a));
            end else begin
               bit_a = $urandom_range(0, 31);
               bit_b = (bit_a + $urandom_range(1, 31)) % 32;
               send_word(hmc32_pkg::MODE_DECODE,
                         cw ^ (32'h1 << bit_a) ^ (32'h1 << bit_b));
            end
            sent++;
         end
         // leave about a third of the bursts back to back
         if ($urandom_range(0, 2) == 0) begin
            continue;
         end
         idle_cycles($urandom_range(1, 6));
      end
      idle_cycles(1);
   endtask

   initial begin
      // Hold reset at the start, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_encode_extremes();
      test_decode_clean();
      test_decode_single_error();
      test_decode_corner_cases();
      test_random_traffic(1900);

      // Drain, then keep watching for stray strobes
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);

      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
